// ===== sv/gbd_pkg.sv =====
// Shared types, codes and rounding helper for the gradient Bayer demosaic.
// No dependencies; imported by the top level, gbd_interp and the testbench.
package gbd_pkg;

  // Widths of the pixel position fields carried between modules
  localparam int ROW_W = 16;
  localparam int POS_COL_W = 15;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_PATTERN = 2'd2
  } cfg_reg_t;

  // Color filter layouts
  typedef enum logic [1:0] {
    PAT_RGGB = 2'd0,
    PAT_BGGR = 2'd1,
    PAT_GRBG = 2'd2,
    PAT_GBRG = 2'd3
  } pattern_t;

  // Control that travels with one output pixel
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic [POS_COL_W-1:0] col;
    logic [ROW_W-1:0]     height;
    logic [POS_COL_W-1:0] width;
    logic                 red_y;
    logic                 red_x;
  } pix_ctl_t;

  // Round a quarter-unit sum half to even and saturate to 8 bits
  function automatic logic [7:0] round_q(input logic [9:0] q);
    logic [8:0] i;
    begin
      i = {1'b0, q[9:2]};
      if (q[1:0] == 2'd3 || (q[1:0] == 2'd2 && i[0])) i = i + 9'd1;
      round_q = (i > 9'd255) ? 8'd255 : i[7:0];
    end
  endfunction

endpackage

// ===== sv/gradient_bayer_demosaic.sv =====
// Top level of the gradient Bayer demosaic: counters, line RAM and interpolation.
// Depends on gbd_pkg, gbd_line_ram and gbd_interp.
//
// Takes one Bayer sample per clock and returns one RGB pixel per clock once the
// window is primed; each pixel leaves 2*width+2 requests after its own sample,
// and the request that completes its window reaches m_tvalid through stage one,
// s2, s3 and the output register. The column history RAM is read and written once
// per request, so the block sustains one request per cycle. After the frame, send
// pad requests (tuser=1) to drain the last two rows and two pixels. A width, height
// or pattern write restarts the frame. Output stalls hold the whole pipeline.
module gradient_bayer_demosaic #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // raw_sample
  input  logic        s_tuser,   // pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out, green_out, blue_out
  output logic        m_tlast    // frame_last
);
  import gbd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = COL_W + 3;

  logic [12:0] frame_width;
  logic [15:0] frame_height;
  pattern_t    pattern;

  logic [COL_W:0]   eff_w;
  logic [15:0]      eff_h;
  logic [COL_W-1:0] in_col, out_col;
  logic [16:0]      in_row;
  logic [15:0]      out_row;
  logic [CNT_W-1:0] cnt, prime;
  logic             advance, take, drain, emit, is_last, clear;

  logic             s1_valid, s1_emit;
  logic [COL_W-1:0] s1_addr;
  logic [7:0]       s1_sample;
  pix_ctl_t         s1_ctl, ctl;
  logic [31:0]      word, wr_word;
  logic [4:0][7:0]  column;
  logic             out_valid;
  logic [7:0]       red, green, blue;
  logic             last;

  // Effective frame size
  always_comb begin
    if (frame_width == 13'd0) eff_w = (COL_W+1)'(1);
    else if (32'(frame_width) > 32'(MAX_WIDTH)) eff_w = (COL_W+1)'(MAX_WIDTH);
    else eff_w = (COL_W+1)'(frame_width);
    eff_h = (frame_height == 16'd0) ? 16'd1 : frame_height;
    prime = {eff_w, 1'b0} + CNT_W'(2);
  end

  assign advance  = !out_valid || m_tready;
  assign s_tready = advance;
  assign drain    = in_row >= {1'b0, eff_h};
  assign take     = s_tvalid && advance && (drain || !s_tuser);
  assign emit     = cnt == prime;
  assign is_last  = ({1'b0, out_row} + 17'd1 == {1'b0, eff_h})
                 && ({1'b0, out_col} + (COL_W+1)'(1) == eff_w);
  assign clear    = cfg_we && (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT
                               || cfg_addr == REG_PATTERN);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 13'd640;
      frame_height <= 16'd480;
      pattern      <= PAT_RGGB;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_WIDTH:   frame_width  <= cfg_wdata[12:0];
        REG_HEIGHT:  frame_height <= cfg_wdata;
        REG_PATTERN: pattern      <= pattern_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      cnt     <= '0;
    end else if (take) begin
      if (emit && is_last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        cnt     <= '0;
      end else begin
        if ({1'b0, in_col} + (COL_W+1)'(1) >= eff_w) begin
          in_col <= '0;
          in_row <= in_row + 17'd1;
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (!emit) cnt <= cnt + CNT_W'(1);
        if (emit) begin
          if ({1'b0, out_col} + (COL_W+1)'(1) >= eff_w) begin
            out_col <= '0;
            out_row <= out_row + 16'd1;
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

  // Stage one: RAM read in flight
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (advance) s1_valid <= take;
    if (advance) begin
      s1_addr      <= in_col;
      s1_sample    <= drain ? 8'd0 : s_tdata;
      s1_emit      <= emit;
      s1_ctl.valid <= 1'b1;
      s1_ctl.last  <= is_last;
      s1_ctl.row   <= out_row;
      s1_ctl.col   <= POS_COL_W'(out_col);
      s1_ctl.height <= eff_h;
      s1_ctl.width <= POS_COL_W'(eff_w);
      s1_ctl.red_y <= (pattern == PAT_BGGR) || (pattern == PAT_GBRG);
      s1_ctl.red_x <= (pattern == PAT_BGGR) || (pattern == PAT_GRBG);
    end
  end

  gbd_line_ram #(.DEPTH(MAX_WIDTH), .AW(COL_W)) u_ram (
    .clk     (clk),
    .en      (advance),
    .rd_addr (in_col),
    .wr_en   (advance && s1_valid),
    .wr_addr (s1_addr),
    .wr_data (wr_word),
    .rd_data (word)
  );

  // Shift the history word and form the new window column, oldest row first
  always_comb begin
    wr_word   = {word[23:0], s1_sample};
    column[0] = word[31:24];
    column[1] = word[23:16];
    column[2] = word[15:8];
    column[3] = word[7:0];
    column[4] = s1_sample;
    ctl       = s1_ctl;
    ctl.valid = s1_valid && s1_emit;
  end

  gbd_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .push      (advance && s1_valid),
    .column    (column),
    .ctl       (ctl),
    .out_valid (out_valid),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .last      (last)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {blue, green, red};
  assign m_tlast  = last;

  // Counters stay inside the frame
  a_in_col: assert property (@(posedge clk) disable iff (rst)
    {1'b0, in_col} < eff_w) else $error("input column out of range");
  a_out_col: assert property (@(posedge clk) disable iff (rst)
    {1'b0, out_col} < eff_w) else $error("output column out of range");
  a_prime: assert property (@(posedge clk) disable iff (rst || cfg_we)
    cnt <= prime) else $error("priming count overran");
endmodule

// ===== sv/gbd_line_ram.sv =====
// Column history RAM: one word per column holding the four previous rows.
// Depends on nothing; read data registered, same-address write forwarded.
module gbd_line_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  output logic [31:0]   rd_data
);
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;
  logic [31:0] fwd_data;
  logic        fwd;

  // Write back and read, holding read data while stalled
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (en) begin
      rdata    <= mem[rd_addr];
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  // Take the word being written in the same cycle as the read
  assign rd_data = fwd ? fwd_data : rdata;
endmodule

// ===== sv/gbd_interp.sv =====
// 5x5 window, gradient and bilinear interpolation, and output register.
// Depends on gbd_pkg.
module gbd_interp (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              push,
  input  logic [4:0][7:0]   column,
  input  gbd_pkg::pix_ctl_t ctl,
  output logic              out_valid,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic              last
);
  import gbd_pkg::*;

  logic [7:0] win [5][5];
  logic [7:0] m   [5][5];
  pix_ctl_t   s2;
  logic [4:0] rok, cok;
  logic [16:0] oy, ox, hh, ww;
  logic        in1, in2, rsite, bsite, rrow;
  logic [9:0]  gh, gv, dg;
  logic [8:0]  hs, vs;

  logic        s3_valid, s3_last, s3_in1, s3_in2, s3_rsite, s3_bsite, s3_rrow;
  logic [7:0]  s3_c;
  logic [9:0]  s3_gh, s3_gv, s3_dg;
  logic [8:0]  s3_hs, s3_vs;
  logic [9:0]  rq, gq, bq;

  function automatic logic [7:0] ad(input logic [7:0] a, input logic [7:0] b);
    ad = (a > b) ? a - b : b - a;
  endfunction

  // Shift a new column into the window
  always_ff @(posedge clk) begin
    if (push) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) win[r][c] <= win[r][c+1];
        win[r][4] <= column[r];
      end
    end
  end

  // Window borders relative to the output pixel
  always_comb begin
    oy = {1'b0, s2.row};
    ox = {2'b0, s2.col};
    hh = {1'b0, s2.height};
    ww = {2'b0, s2.width};
    rok[0] = oy >= 17'd2;
    rok[1] = oy >= 17'd1;
    rok[2] = 1'b1;
    rok[3] = oy + 17'd1 < hh;
    rok[4] = oy + 17'd2 < hh;
    cok[0] = ox >= 17'd2;
    cok[1] = ox >= 17'd1;
    cok[2] = 1'b1;
    cok[3] = ox + 17'd1 < ww;
    cok[4] = ox + 17'd2 < ww;
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++)
        m[r][c] = (rok[r] && cok[c]) ? win[r][c] : 8'd0;
    in1   = rok[1] && rok[3] && cok[1] && cok[3];
    in2   = rok[0] && rok[4] && cok[0] && cok[4];
    rrow  = s2.row[0] == s2.red_y;
    rsite = rrow && (s2.col[0] == s2.red_x);
    bsite = !rrow && (s2.col[0] != s2.red_x);
  end

  // Gradients and neighbor sums
  always_comb begin
    gh = {2'b0, ad(m[2][0], m[2][2])} + {2'b0, ad(m[2][4], m[2][2])}
       + {2'b0, ad(m[2][1], m[2][3])};
    gv = {2'b0, ad(m[0][2], m[2][2])} + {2'b0, ad(m[4][2], m[2][2])}
       + {2'b0, ad(m[1][2], m[3][2])};
    hs = {1'b0, m[2][1]} + {1'b0, m[2][3]};
    vs = {1'b0, m[1][2]} + {1'b0, m[3][2]};
    dg = {2'b0, m[1][1]} + {2'b0, m[1][3]} + {2'b0, m[3][1]} + {2'b0, m[3][3]};
  end

  // Advance control and partial sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s2.valid <= ctl.valid;
      s3_valid <= s2.valid;
    end
    if (advance) begin
      s2.last   <= ctl.last;
      s2.row    <= ctl.row;
      s2.col    <= ctl.col;
      s2.height <= ctl.height;
      s2.width  <= ctl.width;
      s2.red_y  <= ctl.red_y;
      s2.red_x  <= ctl.red_x;
      s3_last  <= s2.last;
      s3_in1   <= in1;
      s3_in2   <= in2;
      s3_rsite <= rsite;
      s3_bsite <= bsite;
      s3_rrow  <= rrow;
      s3_c     <= m[2][2];
      s3_gh    <= gh;
      s3_gv    <= gv;
      s3_dg    <= dg;
      s3_hs    <= hs;
      s3_vs    <= vs;
    end
  end

  // Select quarter sums by site
  always_comb begin
    logic [9:0] gsel;
    gsel = (s3_gh < s3_gv) ? {s3_hs, 1'b0} :
           (s3_gv < s3_gh) ? {s3_vs, 1'b0} : {1'b0, s3_hs} + {1'b0, s3_vs};
    rq = 10'd0;
    gq = 10'd0;
    bq = 10'd0;
    if (s3_rsite) begin
      rq = {s3_c, 2'b0};
      if (s3_in2) gq = gsel;
      if (s3_in1) bq = s3_dg;
    end else if (s3_bsite) begin
      bq = {s3_c, 2'b0};
      if (s3_in2) gq = gsel;
      if (s3_in1) rq = s3_dg;
    end else begin
      gq = {s3_c, 2'b0};
      if (s3_in1) begin
        rq = s3_rrow ? {s3_hs, 1'b0} : {s3_vs, 1'b0};
        bq = s3_rrow ? {s3_vs, 1'b0} : {s3_hs, 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= s3_valid;
    if (advance) begin
      red   <= round_q(rq);
      green <= round_q(gq);
      blue  <= round_q(bq);
      last  <= s3_last;
    end
  end
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for gradient_bayer_demosaic: directed table, then random frames.
// Depends on gbd_pkg and the gradient_bayer_demosaic RTL; needs no files or arguments.
module tb;
  import gbd_pkg::*;

  localparam int LINE_SLOTS = 4096;
  localparam int KEPT_LINES = 5;
  localparam int ITEM_GOAL = 1250;
  localparam int SETTLE_CYCLES = 16;
  localparam int WIDE_LIMIT = 64;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  addr;
    logic [15:0] value;
    logic [7:0]  sample;
    logic        pad;
    logic        typed;
    pixel_t      want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // raw_sample
  logic        s_tuser = 1'b0; // pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // red_out, green_out, blue_out
  logic        m_tlast;        // frame_last

  gradient_bayer_demosaic dut (.*);

  // Predictor state
  logic [7:0]  line_mem [0:KEPT_LINES*LINE_SLOTS-1];
  logic [12:0] cur_width = 13'd640;
  logic [15:0] cur_height = 16'd480;
  logic [1:0]  cur_layout = PAT_RGGB;
  int unsigned in_col, in_line, out_col, out_line;

  pixel_t expected_pixels [$];
  int errors = 0;
  int pixels_seen = 0;
  int items_sent = 0;
  int frames_done = 0;
  bit calm = 1'b0;

  initial forever #5 clk = ~clk;

  // Stop a hung run
  initial begin
    #50_000_000;
    $display("[gradient_bayer_demosaic] ERROR");
    $finish;
  end

  function automatic int unsigned eff_width();
    if (cur_width == 0) return 1;
    if (cur_width > LINE_SLOTS) return LINE_SLOTS;
    return cur_width;
  endfunction

  function automatic int unsigned eff_height();
    return (cur_height == 0) ? 1 : cur_height;
  endfunction

  // Pixel of the current frame, zero outside it
  function automatic int nb(int y, int x);
    if (y < 0 || y >= int'(eff_height()) || x < 0 || x >= int'(eff_width())) return 0;
    return line_mem[(y % KEPT_LINES) * LINE_SLOTS + x];
  endfunction

  function automatic int absval(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [7:0] quarters_to_byte(int unsigned q);
    int unsigned i;
    i = q >> 2;
    if ((q & 3) == 3 || ((q & 3) == 2 && i[0])) i++;
    return (i > 255) ? 8'd255 : i[7:0];
  endfunction

  // Green at a red or blue site: follow the flatter direction, average on a tie
  function automatic int unsigned green_at(int y, int x);
    int c, gh, gv, hs, vs;
    c = nb(y, x);
    gh = absval(nb(y, x-2) - c) + absval(nb(y, x+2) - c) + absval(nb(y, x-1) - nb(y, x+1));
    gv = absval(nb(y-2, x) - c) + absval(nb(y+2, x) - c) + absval(nb(y-1, x) - nb(y+1, x));
    hs = nb(y, x-1) + nb(y, x+1);
    vs = nb(y-1, x) + nb(y+1, x);
    if (gh < gv) return 2 * hs;
    if (gv < gh) return 2 * vs;
    return hs + vs;
  endfunction

  // Advance the predictor by one accepted request; has_pixel tells if one leaves
  task automatic demosaic_step(input logic [7:0] sample, input logic pad,
                               output bit has_pixel, output pixel_t pix);
    int unsigned w, h, rq, gq, bq, hq, vq;
    longint unsigned pos;
    int y, x;
    bit ry, rx, yb, xb, in1, in2, last;
    w = eff_width();
    h = eff_height();
    has_pixel = 1'b0;
    pix = '0;
    if (in_line < h) begin
      if (pad) return;
      line_mem[(in_line % KEPT_LINES) * LINE_SLOTS + in_col] = sample;
    end
    pos = longint'(in_line) * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_line++;
    end
    if (pos < 2 * longint'(w) + 2) return;
    y = out_line;
    x = out_col;
    ry = (cur_layout == PAT_BGGR || cur_layout == PAT_GBRG);
    rx = (cur_layout == PAT_BGGR || cur_layout == PAT_GRBG);
    yb = out_line[0];
    xb = out_col[0];
    in1 = out_line >= 1 && out_line + 1 < h && out_col >= 1 && out_col + 1 < w;
    in2 = out_line >= 2 && out_line + 2 < h && out_col >= 2 && out_col + 2 < w;
    rq = 0;
    gq = 0;
    bq = 0;
    if (yb == ry && xb == rx) begin
      rq = 4 * nb(y, x);
      if (in2) gq = green_at(y, x);
      if (in1) bq = nb(y-1, x-1) + nb(y-1, x+1) + nb(y+1, x-1) + nb(y+1, x+1);
    end else if (yb != ry && xb != rx) begin
      bq = 4 * nb(y, x);
      if (in2) gq = green_at(y, x);
      if (in1) rq = nb(y-1, x-1) + nb(y-1, x+1) + nb(y+1, x-1) + nb(y+1, x+1);
    end else begin
      hq = 2 * (nb(y, x-1) + nb(y, x+1));
      vq = 2 * (nb(y-1, x) + nb(y+1, x));
      gq = 4 * nb(y, x);
      if (in1) begin
        rq = (yb == ry) ? hq : vq;
        bq = (yb == ry) ? vq : hq;
      end
    end
    last = (out_line + 1 == h && out_col + 1 == w);
    pix.red = quarters_to_byte(rq);
    pix.green = quarters_to_byte(gq);
    pix.blue = quarters_to_byte(bq);
    pix.last = last;
    has_pixel = 1'b1;
    if (last) begin
      {in_col, in_line, out_col, out_line} = '0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_line++;
      end
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    errors++;
    $display("mismatch at pixel %0d: %s got %0d expected %0d", pixels_seen, what, got, want);
  endtask

  // Compare each delivered pixel with the oldest prediction
  always @(posedge clk) begin
    pixel_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        report("unexpected pixel, red", m_tdata[7:0], 8'd0);
      end else begin
        w = expected_pixels.pop_front();
        if (m_tdata[7:0] != w.red) report("red", m_tdata[7:0], w.red);
        if (m_tdata[15:8] != w.green) report("green", m_tdata[15:8], w.green);
        if (m_tdata[23:16] != w.blue) report("blue", m_tdata[23:16], w.blue);
        if (m_tlast != w.last) report("last", 8'(m_tlast), 8'(w.last));
        if (w.last) frames_done++;
      end
      pixels_seen++;
    end
  end

  // Random backpressure on the pixel side
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Send one request and record its prediction, or a typed value where given
  task automatic send(input logic [7:0] sample, input logic pad,
                      input logic typed = 1'b0, input pixel_t want = '0);
    int unsigned gap;
    bit has_pixel;
    pixel_t pix;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= sample;
    s_tuser <= pad;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    demosaic_step(sample, pad, has_pixel, pix);
    if (typed) begin
      if (!has_pixel) report("directed row without pixel", 8'd0, 8'd1);
      expected_pixels.push_back(want);
    end else if (has_pixel) begin
      expected_pixels.push_back(pix);
    end
  endtask

  // Hold until every pixel is out, then let the pipeline settle
  task automatic drain_wait();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      REG_WIDTH:   cur_width = value[12:0];
      REG_HEIGHT:  cur_height = value;
      REG_PATTERN: cur_layout = value[1:0];
      default:     return;
    endcase
    {in_col, in_line, out_col, out_line} = '0;
  endtask

  function automatic dir_row_t wr(input logic [1:0] addr, input logic [15:0] value);
    return '{ROW_WRITE, addr, value, 8'd0, 1'b0, 1'b0, pixel_t'(0)};
  endfunction

  function automatic dir_row_t it(input logic [7:0] sample, input logic pad,
                                  input logic typed = 1'b0, input pixel_t want = '0);
    return '{ROW_ITEM, REG_WIDTH, 16'd0, sample, pad, typed, want};
  endfunction

  dir_row_t directed [$];

  initial begin
    int unsigned w, h, cut, n;
    bit flat, cut_short, redo;
    logic [7:0] s;

    // Single-pixel frames: pass-through at each site kind, ignored pad, sample in drain
    directed = '{
      wr(REG_WIDTH, 16'd1), wr(REG_HEIGHT, 16'd1), wr(REG_PATTERN, 16'(PAT_RGGB)),
      it(8'hFF, 1'b0), it(8'h00, 1'b1), it(8'h00, 1'b1), it(8'h00, 1'b1),
      it(8'h00, 1'b1, 1'b1, pixel_t'{8'd255, 8'd0, 8'd0, 1'b1}),
      wr(REG_PATTERN, 16'(PAT_BGGR)),
      it(8'h77, 1'b1), it(8'h00, 1'b0), it(8'hFF, 1'b0), it(8'h00, 1'b1), it(8'h00, 1'b1),
      it(8'h00, 1'b1, 1'b1, pixel_t'{8'd0, 8'd0, 8'd0, 1'b1}),
      wr(REG_WIDTH, 16'd0), wr(REG_HEIGHT, 16'd0), wr(REG_PATTERN, 16'(PAT_GRBG)),
      wr(REG_SPARE, 16'hFFFF),
      it(8'h80, 1'b0), it(8'h00, 1'b1), it(8'h00, 1'b1), it(8'h00, 1'b1),
      it(8'h00, 1'b1, 1'b1, pixel_t'{8'd0, 8'd128, 8'd0, 1'b1}),
      wr(REG_WIDTH, 16'h1FFF), wr(REG_HEIGHT, 16'hFFFF), wr(REG_PATTERN, 16'(PAT_GBRG)),
      it(8'h55, 1'b0), it(8'hAA, 1'b0)
    };

    for (int i = 0; i < 5; i++) line_mem[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        drain_wait();
        write_reg(directed[i].addr, directed[i].value);
      end else begin
        send(directed[i].sample, directed[i].pad, directed[i].typed, directed[i].want);
      end
    end

    // Random frames, mostly small, a few at full line width that stop early, some cut short
    redo = 1'b1;
    while (items_sent < ITEM_GOAL) begin
      if (redo || $urandom_range(0, 3) == 0) begin
        drain_wait();
        n = $urandom_range(0, 39);
        if (n == 0) begin
          w = 4096;
          h = $urandom_range(1, 2);
        end else if (n == 1) begin
          w = 8191;
          h = 1;
        end else if (n == 2) begin
          w = 0;
          h = $urandom_range(0, 3);
        end else begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 8);
        end
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        write_reg(REG_PATTERN, 16'($urandom_range(0, 3)));
        redo = 1'b0;
      end
      calm = ($urandom_range(0, 4) == 0);
      flat = ($urandom_range(0, 3) == 0);
      w = eff_width();
      h = eff_height();
      cut_short = ($urandom_range(0, 19) == 0);
      cut = $urandom_range(1, w * h);
      // Keep wide frames short so the run stays near its item budget
      if (w > WIDE_LIMIT) begin
        cut_short = 1'b1;
        cut = $urandom_range(1, WIDE_LIMIT);
      end
      for (int unsigned i = 0; i < w * h; i++) begin
        if ($urandom_range(0, 19) == 0) send(8'($urandom), 1'b1);
        n = $urandom_range(0, 9);
        s = flat ? 8'($urandom_range(0, 3)) :
            (n == 0) ? 8'd0 : (n == 1) ? 8'd255 : 8'($urandom);
        send(s, 1'b0);
        items_sent++;
        if (cut_short && i + 1 == cut) break;
      end
      if (cut_short) begin
        redo = 1'b1;
        continue;
      end
      // Drain the lag of two rows and two pixels, now and then with a sample that acts as a pad
      for (int unsigned i = 0; i < 2 * w + 2; i++) begin
        send(8'($urandom), ($urandom_range(0, 7) != 0));
        items_sent++;
      end
    end

    drain_wait();
    $display("covered %0d requests, %0d pixels checked over %0d completed frames",
             items_sent, pixels_seen, frames_done);
    if (errors == 0) begin
      $display("[gradient_bayer_demosaic] OK");
    end else begin
      $display("[gradient_bayer_demosaic] ERROR");
    end
    $finish;
  end

endmodule
